// ----- src/bwrn_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and helper functions for the Bloom-filter RAM node.
// Used by bwrn_ctrl, bwrn_datapath and bloom_weightless_ram_node; no dependencies.
package bwrn_pkg;

    localparam int MAX_FILTER_BITS = 12;
    localparam int CLASS_COUNT     = 16;
    localparam int TUPLE_BITS      = 4;
    localparam int NUM_SLICES      = 4;
    localparam int SLICE_W         = 16;
    localparam int KEY_W           = 64;
    localparam int ADDR_W          = MAX_FILTER_BITS;
    localparam int CLASS_W         = CLASS_COUNT;
    localparam int CLASS_IDX_W     = 4;
    localparam int SLICE_IDX_W     = 2;
    localparam int CFG_IDX_W       = 3;
    localparam int OUT_W           = 16;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TUPLE_LENGTH = 3'd0,
        REG_NUM_HASHES   = 3'd1,
        REG_FILTER_BITS  = 3'd2,
        REG_KEY_0        = 3'd3,
        REG_KEY_1        = 3'd4,
        REG_KEY_2        = 3'd5,
        REG_KEY_3        = 3'd6
    } cfg_reg_t;

    // Item modes as carried on tuser.
    localparam logic MODE_TRAIN   = 1'b0;
    localparam logic MODE_PREDICT = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_MODIFY,
        ST_DONE
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic              load;
        logic              clear_en;
        logic [ADDR_W-1:0] clear_addr;
        logic              rd_en;
        logic              mod_en;
        logic [SLICE_IDX_W-1:0] slice;
        logic              out_load;
    } bwrn_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [SLICE_IDX_W-1:0] last_slice;
        logic                   out_full;
    } bwrn_status_t;

    // Number of tuple bits in use, limited to 1..TUPLE_BITS.
    function automatic logic [2:0] clamp_tuple_len(input logic [2:0] v);
        logic [2:0] r;
        if (v == 3'd0)
            r = 3'd1;
        else if (v > 3'(TUPLE_BITS))
            r = 3'(TUPLE_BITS);
        else
            r = v;
        return r;
    endfunction

    // Index of the last hash slice in use, from a count limited to 1..4.
    function automatic logic [SLICE_IDX_W-1:0] last_slice_of(input logic [2:0] v);
        logic [SLICE_IDX_W-1:0] r;
        if (v == 3'd0)
            r = '0;
        else if (v > 3'(NUM_SLICES))
            r = SLICE_IDX_W'(NUM_SLICES - 1);
        else
            r = SLICE_IDX_W'(v - 3'd1);
        return r;
    endfunction

    // Address mask for a filter width limited to 1..MAX_FILTER_BITS.
    function automatic logic [ADDR_W-1:0] addr_mask_of(input logic [3:0] v);
        logic [3:0]      fb;
        logic [ADDR_W:0] m;
        if (v == 4'd0)
            fb = 4'd1;
        else if (v > 4'(MAX_FILTER_BITS))
            fb = 4'(MAX_FILTER_BITS);
        else
            fb = v;
        m = ((ADDR_W+1)'(1) << fb) - (ADDR_W+1)'(1);
        return m[ADDR_W-1:0];
    endfunction

endpackage

// ----- src/bwrn_datapath.sv -----
`timescale 1ns / 1ps
// Datapath of the Bloom-filter RAM node: configuration registers, hash register,
// single-port filter store, match accumulator and output register. Uses bwrn_pkg.
module bwrn_datapath
    import bwrn_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [KEY_W-1:0]      cfg_data,
    input  logic                  in_mode,
    input  logic [TUPLE_BITS-1:0] in_tuple_bits,
    input  logic [CLASS_IDX_W-1:0] in_class_index,
    input  bwrn_cmd_t             cmd,
    output bwrn_status_t          status,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_W-1:0]      m_tdata
);

    logic [2:0]       tuple_length_reg;
    logic [2:0]       num_hashes_reg;
    logic [3:0]       filter_bits_reg;
    logic [KEY_W-1:0] key_reg [TUPLE_BITS];

    logic [KEY_W-1:0]       hash_reg, hash_next;
    logic                   mode_reg;
    logic [CLASS_IDX_W-1:0] class_reg;
    logic [CLASS_W-1:0]     rdata_reg;
    logic [CLASS_W-1:0]     match_reg;
    logic [OUT_W-1:0]       out_data_reg;
    logic                   out_valid_reg;

    logic [CLASS_W-1:0] store [1 << ADDR_W];
    logic [ADDR_W-1:0]  mem_addr;
    logic [ADDR_W-1:0]  hash_addr;
    logic               mem_we;
    logic [CLASS_W-1:0] mem_wdata;
    logic [CLASS_W-1:0] class_bit;
    logic [2:0]         tuple_len;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tuple_length_reg <= 3'd4;
            num_hashes_reg   <= 3'd4;
            filter_bits_reg  <= 4'd10;
            for (int i = 0; i < TUPLE_BITS; i++)
                key_reg[i] <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_TUPLE_LENGTH: tuple_length_reg <= cfg_data[2:0];
                REG_NUM_HASHES:   num_hashes_reg   <= cfg_data[2:0];
                REG_FILTER_BITS:  filter_bits_reg  <= cfg_data[3:0];
                REG_KEY_0:        key_reg[0]       <= cfg_data;
                REG_KEY_1:        key_reg[1]       <= cfg_data;
                REG_KEY_2:        key_reg[2]       <= cfg_data;
                REG_KEY_3:        key_reg[3]       <= cfg_data;
                default:          ;
            endcase
        end
    end

    // XOR of the keys whose tuple bits are set, over the bits in use.
    always_comb
    begin
        tuple_len = clamp_tuple_len(tuple_length_reg);
        hash_next = '0;
        for (int n = 0; n < TUPLE_BITS; n++)
            if (in_tuple_bits[n] && (3'(n) < tuple_len))
                hash_next = hash_next ^ key_reg[n];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            hash_reg  <= hash_next;
            mode_reg  <= in_mode;
            class_reg <= in_class_index;
        end
    end

    assign hash_addr = hash_reg[{cmd.slice, 4'b0000} +: ADDR_W]
                       & addr_mask_of(filter_bits_reg);
    assign class_bit = (32'(class_reg) < CLASS_COUNT)
                       ? (CLASS_W'(1) << class_reg) : '0;

    always_comb
    begin
        mem_addr  = cmd.clear_en ? cmd.clear_addr : hash_addr;
        mem_we    = cmd.clear_en || (cmd.mod_en && (mode_reg == MODE_TRAIN));
        mem_wdata = cmd.clear_en ? '0 : (rdata_reg | class_bit);
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            store[mem_addr] <= mem_wdata;
        else if (cmd.rd_en)
            rdata_reg <= store[mem_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            match_reg <= '1;
        else if (cmd.mod_en)
            match_reg <= match_reg & rdata_reg;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
            out_data_reg <= (mode_reg == MODE_PREDICT) ? match_reg[OUT_W-1:0] : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    assign status.last_slice = last_slice_of(num_hashes_reg);
    assign status.out_full   = out_valid_reg;
    assign m_tvalid          = out_valid_reg;
    assign m_tdata           = out_data_reg;

`ifndef SYNTHESIS
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || m_tready))
        else $error("output word overwritten before it was taken");
`endif

endmodule

// ----- src/bwrn_ctrl.sv -----
`timescale 1ns / 1ps
// Controller of the Bloom-filter RAM node: clearing sweep and the per-item
// read/modify sequence over the hash slices. Uses bwrn_pkg.
module bwrn_ctrl
    import bwrn_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  bwrn_status_t status,
    input  logic         m_tready,
    output bwrn_cmd_t    cmd
);

    state_t                 state_reg, state_next;
    logic [SLICE_IDX_W-1:0] slice_reg, slice_next;
    logic [ADDR_W-1:0]      clear_reg, clear_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            slice_reg <= '0;
            clear_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            slice_reg <= slice_next;
            clear_reg <= clear_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        slice_next     = slice_reg;
        clear_next     = clear_reg;
        s_tready       = 1'b0;
        cmd            = '0;
        cmd.clear_addr = clear_reg;
        cmd.slice      = slice_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_en = 1'b1;
                clear_next   = clear_reg + 1'b1;
                if (clear_reg == '1)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    slice_next = '0;
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                cmd.rd_en  = 1'b1;
                state_next = ST_MODIFY;
            end
            ST_MODIFY:
            begin
                cmd.mod_en = 1'b1;
                if (slice_reg == status.last_slice)
                    state_next = ST_DONE;
                else
                begin
                    slice_next = slice_reg + 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_DONE:
            begin
                if (!status.out_full || m_tready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

`ifndef SYNTHESIS
    a_mod_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mod_en |-> $past(cmd.rd_en))
        else $error("modify step without a preceding store read");
    a_slice_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.rd_en || cmd.mod_en) |-> (slice_reg <= status.last_slice))
        else $error("hash slice index beyond the configured count");
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (state_reg == ST_READ && slice_reg == '0))
        else $error("accepted word did not start at the first slice");
`endif

endmodule

// ----- src/bloom_weightless_ram_node.sv -----
`timescale 1ns / 1ps
// Bloom-filter RAM node of a weightless neural network, top level.
// Each accepted input word takes H read/modify pairs on the single-port store, where
// H (1..4) is the hash count, and then waits until the output register is free.
// No new word is accepted until its result has been loaded into the output register.
// Reset (rst_n, asynchronous, active low): a clearing pass zeroes the store,
// during which no word is accepted; configuration writes are taken throughout.
module bloom_weightless_ram_node
    import bwrn_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // Configuration: register index 0 tuple_length, 1 num_hashes, 2 filter_bits,
    // 3..6 key_0..key_3. Indexes above 6 are ignored.
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [KEY_W-1:0]     cfg_data,
    // Input word stream.
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,   // [3:0] tuple_bits, [7:4] class_index
    input  logic                 s_tuser,   // [0] mode (0 train, 1 predict)
    // Result word stream.
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [OUT_W-1:0]     m_tdata    // [15:0] class_match
);

    bwrn_cmd_t    cmd;
    bwrn_status_t status;

    // The controller walks the clearing sweep after reset and then, for every
    // accepted word, one read and one modify step per hash slice. In training
    // the modify step writes the class bit back; in prediction it ANDs the
    // stored class bits into the match accumulator.
    bwrn_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    // The datapath holds the configuration, computes the key XOR hash when a
    // word is accepted, owns the filter store and the output register. The
    // output register lets a new word be accepted while a result still waits.
    bwrn_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_mode        (s_tuser),
        .in_tuple_bits  (s_tdata[3:0]),
        .in_class_index (s_tdata[7:4]),
        .cmd            (cmd),
        .status         (status),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata)
    );

endmodule

// ----- tb/tb_bloom_weightless_ram_node.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for bloom_weightless_ram_node: a directed table, then random phases.
// Depends on bwrn_pkg and the RTL under src; every result word is predicted inside the bench.
module tb_bloom_weightless_ram_node;
    import bwrn_pkg::*;

    // The watchdog must outlast the clearing pass after reset and the long hold-off.
    localparam int WATCHDOG_LIMIT  = 20000;
    // Settling time allowed before a register write, above the longest word latency.
    localparam int SETTLE_CYCLES   = 12;
    localparam int END_CYCLES      = 40;
    localparam int HOLD_CYCLES     = 300;
    localparam int NUM_PHASES      = 12;
    localparam int WORDS_PER_PHASE = 150;
    localparam int MAX_PRINTS      = 40;
    // An index past the last register; writes to it must change nothing.
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    typedef enum logic { ROW_WORD, ROW_REG } row_kind_t;

    // One row of the directed table: either an input word or a register write.
    typedef struct packed {
        row_kind_t            kind;
        logic                 mode;
        logic [3:0]           tuple_bits;
        logic [3:0]           class_index;
        logic [CFG_IDX_W-1:0] reg_index;
        logic [KEY_W-1:0]     reg_value;
        logic                 fixed;        // the expected word is typed into the row
        logic [OUT_W-1:0]     fixed_match;
    } dir_row_t;

    typedef struct packed {
        int unsigned      seq;
        logic [OUT_W-1:0] match;
    } pending_t;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [KEY_W-1:0]     cfg_data  = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [7:0]           s_tdata   = '0;   // [3:0] tuple_bits, [7:4] class_index
    logic                 s_tuser   = 1'b0; // [0] mode
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [OUT_W-1:0]     m_tdata;          // [15:0] class_match

    // Shadow copy of the node: configuration and filter contents.
    logic [2:0]           tuple_len_q = 3'd4;
    logic [2:0]           hashes_q    = 3'd4;
    logic [3:0]           fbits_q     = 4'd10;
    logic [KEY_W-1:0]     keys_q [TUPLE_BITS];
    logic [CLASS_W-1:0]   filter_q [1 << MAX_FILTER_BITS];

    pending_t             pending_matches [$];
    dir_row_t             dir_tab [$];
    int                   err_count       = 0;
    int                   idle_cycles     = 0;
    int unsigned          words_sent      = 0;
    int unsigned          words_seen      = 0;
    int unsigned          send_gap_pct    = 20;
    int unsigned          recv_stall_pct  = 20;
    bit                   no_idle         = 1'b0;
    bit                   hold_req        = 1'b0;
    bit                   hold_done       = 1'b0;
    bit                   words_in_flight = 1'b0;

    bloom_weightless_ram_node uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #5 clk = ~clk;

    // Applies one word to the shadow filter and returns the class_match the node
    // should answer. Out-of-range register values are pulled into their legal
    // ranges, and tuple bits at or above the tuple length never reach the hash.
    function automatic logic [OUT_W-1:0] apply_word(input logic md, input logic [3:0] bits,
                                                    input logic [3:0] cls);
        int unsigned       len;
        int unsigned       cnt;
        int unsigned       width;
        logic [KEY_W-1:0]  hash;
        logic [ADDR_W-1:0] mask;
        logic [ADDR_W-1:0] addr;
        logic [CLASS_W-1:0] hit;
        len   = (tuple_len_q == 0) ? 1 : (tuple_len_q > TUPLE_BITS) ? TUPLE_BITS : tuple_len_q;
        cnt   = (hashes_q == 0) ? 1 : (hashes_q > NUM_SLICES) ? NUM_SLICES : hashes_q;
        width = (fbits_q == 0) ? 1 : (fbits_q > MAX_FILTER_BITS) ? MAX_FILTER_BITS : fbits_q;
        mask  = ADDR_W'((1 << width) - 1);
        hash  = '0;
        for (int n = 0; n < len; n++)
            if (bits[n])
                hash ^= keys_q[n];
        hit = '1;
        for (int k = 0; k < cnt; k++)
        begin
            // Each slice is 16 bits wide, but the mask never keeps more than 12 of them.
            addr = hash[SLICE_W*k +: ADDR_W] & mask;
            if (md == MODE_TRAIN)
                filter_q[addr][cls] = 1'b1;
            else
                hit &= filter_q[addr];
        end
        return (md == MODE_TRAIN) ? '0 : hit[OUT_W-1:0];
    endfunction

    function automatic dir_row_t word_row(input logic md, input logic [3:0] bits,
                                          input logic [3:0] cls, input logic fixed,
                                          input logic [OUT_W-1:0] match);
        dir_row_t r;
        r             = '0;
        r.kind        = ROW_WORD;
        r.mode        = md;
        r.tuple_bits  = bits;
        r.class_index = cls;
        r.fixed       = fixed;
        r.fixed_match = match;
        return r;
    endfunction

    function automatic dir_row_t reg_row(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [KEY_W-1:0] val);
        dir_row_t r;
        r           = '0;
        r.kind      = ROW_REG;
        r.reg_index = idx;
        r.reg_value = val;
        return r;
    endfunction

    // Appends one row to the end of the directed table.
    task automatic add_row(input dir_row_t r);
        dir_tab.insert(dir_tab.size(), r);
    endtask

    task automatic report_mismatch(input string what, input int unsigned seq,
                                   input logic [OUT_W-1:0] got, input logic [OUT_W-1:0] want);
        if (err_count < MAX_PRINTS)
            $display("MISMATCH %s: word %0d class_match %h, wanted %h", what, seq, got, want);
        err_count++;
    endtask

    // Writes one register. If words went in since the last write, the input is
    // dropped first and the node is given time to finish before the write.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [KEY_W-1:0] val);
        if (words_in_flight)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
            wait (pending_matches.size() == 0);
            repeat (SETTLE_CYCLES) @(negedge clk);
            words_in_flight = 1'b0;
        end
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            REG_TUPLE_LENGTH: tuple_len_q = val[2:0];
            REG_NUM_HASHES:   hashes_q    = val[2:0];
            REG_FILTER_BITS:  fbits_q     = val[3:0];
            REG_KEY_0, REG_KEY_1, REG_KEY_2, REG_KEY_3:
                keys_q[2'(idx - REG_KEY_0)] = val;
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Offers one input word, possibly after a random gap, and records the
    // expected result once the word has been taken.
    task automatic offer_word(input logic md, input logic [3:0] bits, input logic [3:0] cls,
                              input logic fixed, input logic [OUT_W-1:0] fixed_match);
        int unsigned      gap;
        logic [OUT_W-1:0] want;
        pending_t         entry;
        if (!no_idle && $urandom_range(99) < send_gap_pct)
        begin
            gap = $urandom_range(1, 15);
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tuser  <= md;
        s_tdata  <= {cls, bits};
        do
            @(posedge clk);
        while (!s_tready);
        want = apply_word(md, bits, cls);
        if (fixed)
            want = fixed_match;
        entry.seq   = words_sent;
        entry.match = want;
        pending_matches.insert(pending_matches.size(), entry);
        words_sent++;
        words_in_flight = 1'b1;
    endtask

    // Result side: random stall bursts, one long hold-off on request, and no
    // stalls at all once the last phase starts.
    initial
    begin : result_sink
        int unsigned gap;
        forever
        begin
            @(negedge clk);
            if (hold_req && !hold_done)
            begin
                // Long hold-off: the node's output fills and its input must stall.
                hold_done = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
            end
            else if (!no_idle && $urandom_range(99) < recv_stall_pct)
            begin
                gap = $urandom_range(1, 15);
                m_tready <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            else
                m_tready <= 1'b1;
        end
    end

    // Every accepted result word is checked against the oldest expectation.
    always @(posedge clk)
    begin
        pending_t head;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_matches.size() == 0)
                report_mismatch("result word with nothing pending", words_seen, m_tdata, '0);
            else
            begin
                head = pending_matches.pop_front();
                if (m_tdata !== head.match)
                    report_mismatch("class_match differs", head.seq, m_tdata, head.match);
            end
            words_seen++;
        end
    end

    // Watchdog: ends the run when nothing moves on either stream for too long.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb_bloom_weightless_ram_node failed");
            $finish;
        end
    end

    initial
    begin : stimulus
        dir_row_t         row;
        logic [KEY_W-1:0] key;
        int unsigned      p;
        int unsigned      i;
        foreach (filter_q[a])
            filter_q[a] = '0;
        foreach (keys_q[n])
            keys_q[n] = '0;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part. With the keys still zero every tuple hashes to zero, so
        // all addresses fall on entry 0 and the answers can be typed in.
        add_row(word_row(MODE_PREDICT, 4'd0,  4'd0,  1'b1, 16'h0000)); // empty store
        add_row(word_row(MODE_TRAIN,   4'd0,  4'd0,  1'b1, 16'h0000));
        add_row(word_row(MODE_PREDICT, 4'd5,  4'd9,  1'b1, 16'h0001));
        add_row(word_row(MODE_TRAIN,   4'd15, 4'd15, 1'b1, 16'h0000));
        add_row(word_row(MODE_PREDICT, 4'd15, 4'd3,  1'b1, 16'h8001));
        // Real keys and the widest filter.
        add_row(reg_row(REG_KEY_0, 64'hFFFF_FFFF_FFFF_FFFF));
        add_row(reg_row(REG_KEY_1, 64'h0123_4567_89AB_CDEF));
        add_row(reg_row(REG_KEY_2, 64'h8000_0000_0000_0001));
        add_row(reg_row(REG_KEY_3, 64'h5A5A_C3C3_0F0F_F00F));
        add_row(reg_row(REG_FILTER_BITS, 64'd12));
        add_row(word_row(MODE_TRAIN,   4'd1,  4'd3,  1'b1, 16'h0000));
        add_row(word_row(MODE_PREDICT, 4'd1,  4'd0,  1'b0, 16'h0000));
        add_row(word_row(MODE_PREDICT, 4'd2,  4'd0,  1'b0, 16'h0000));
        add_row(word_row(MODE_TRAIN,   4'd15, 4'd7,  1'b1, 16'h0000));
        add_row(word_row(MODE_PREDICT, 4'd15, 4'd0,  1'b0, 16'h0000));
        // Zero in all three sizes: each is taken as one.
        add_row(reg_row(REG_TUPLE_LENGTH, 64'd0));
        add_row(reg_row(REG_NUM_HASHES,   64'd0));
        add_row(reg_row(REG_FILTER_BITS,  64'd0));
        add_row(word_row(MODE_TRAIN,   4'd14, 4'd1,  1'b1, 16'h0000));
        add_row(word_row(MODE_PREDICT, 4'd14, 4'd0,  1'b0, 16'h0000));
        add_row(word_row(MODE_PREDICT, 4'd1,  4'd0,  1'b0, 16'h0000));
        // Sizes at the top of their fields are pulled down to the maxima, and a
        // write past the last register is dropped.
        add_row(reg_row(REG_TUPLE_LENGTH, 64'd7));
        add_row(reg_row(REG_NUM_HASHES,   64'd7));
        add_row(reg_row(REG_FILTER_BITS,  64'd15));
        add_row(reg_row(REG_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF));
        add_row(word_row(MODE_TRAIN,   4'd8,  4'd12, 1'b1, 16'h0000));
        add_row(word_row(MODE_PREDICT, 4'd8,  4'd0,  1'b0, 16'h0000));
        add_row(word_row(MODE_PREDICT, 4'd7,  4'd0,  1'b0, 16'h0000));
        // Smallest legal sizes.
        add_row(reg_row(REG_TUPLE_LENGTH, 64'd1));
        add_row(reg_row(REG_NUM_HASHES,   64'd1));
        add_row(reg_row(REG_FILTER_BITS,  64'd1));
        add_row(word_row(MODE_TRAIN,   4'd3,  4'd5,  1'b1, 16'h0000));
        add_row(word_row(MODE_PREDICT, 4'd2,  4'd0,  1'b0, 16'h0000));
        // Just past the maxima.
        add_row(reg_row(REG_TUPLE_LENGTH, 64'd5));
        add_row(reg_row(REG_NUM_HASHES,   64'd5));
        add_row(reg_row(REG_FILTER_BITS,  64'd13));
        add_row(word_row(MODE_PREDICT, 4'd9,  4'd0,  1'b0, 16'h0000));
        add_row(word_row(MODE_TRAIN,   4'd9,  4'd10, 1'b1, 16'h0000));
        add_row(word_row(MODE_PREDICT, 4'd9,  4'd0,  1'b0, 16'h0000));

        foreach (dir_tab[r])
        begin
            row = dir_tab[r];
            if (row.kind == ROW_REG)
                write_reg(row.reg_index, row.reg_value);
            else
                offer_word(row.mode, row.tuple_bits, row.class_index, row.fixed,
                           row.fixed_match);
        end

        // Random phases. The store is never cleared in between, so later phases
        // read bits that earlier settings wrote.
        for (p = 0; p < NUM_PHASES; p++)
        begin
            write_reg(REG_TUPLE_LENGTH, ($urandom_range(3) == 0) ? KEY_W'($urandom_range(7))
                                                                 : KEY_W'($urandom_range(1, 4)));
            write_reg(REG_NUM_HASHES, ($urandom_range(3) == 0) ? KEY_W'($urandom_range(7))
                                                               : KEY_W'($urandom_range(1, 4)));
            // Narrow filters give many hits; wide ones spread the addresses.
            case ($urandom_range(3))
                0:       write_reg(REG_FILTER_BITS, KEY_W'($urandom_range(15)));
                1:       write_reg(REG_FILTER_BITS, KEY_W'($urandom_range(10, 12)));
                default: write_reg(REG_FILTER_BITS, KEY_W'($urandom_range(1, 5)));
            endcase
            for (i = 0; i < TUPLE_BITS; i++)
            begin
                case ($urandom_range(3))
                    0:       key = '0;
                    1:       key = KEY_W'(1) << $urandom_range(KEY_W - 1);
                    default: key = {$urandom, $urandom};
                endcase
                write_reg(CFG_IDX_W'(REG_KEY_0 + i), key);
            end
            if ($urandom_range(3) == 0)
                write_reg(REG_UNUSED, {$urandom, $urandom});

            no_idle = (p == NUM_PHASES - 1);
            case ($urandom_range(2))
                0:       send_gap_pct = 0;
                1:       send_gap_pct = 10;
                default: send_gap_pct = 35;
            endcase
            case ($urandom_range(2))
                0:       recv_stall_pct = 0;
                1:       recv_stall_pct = 10;
                default: recv_stall_pct = 35;
            endcase
            if (p == 1)
            begin
                // The sender keeps offering back to back while the sink holds off.
                send_gap_pct = 0;
                hold_req     = 1'b1;
            end

            for (i = 0; i < WORDS_PER_PHASE; i++)
                offer_word(($urandom_range(99) < 40) ? MODE_TRAIN : MODE_PREDICT,
                           4'($urandom_range(15)), 4'($urandom_range(15)), 1'b0, '0);
        end

        @(negedge clk);
        s_tvalid <= 1'b0;
        wait (pending_matches.size() == 0);
        repeat (END_CYCLES) @(posedge clk);
        if (err_count == 0)
            $display("tb_bloom_weightless_ram_node passed");
        else
            $display("tb_bloom_weightless_ram_node failed");
        $finish;
    end

endmodule
